/* src/qfa_pkg.sv */
`timescale 1ns / 1ps
package qfa_pkg;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_MUL  = 4'd2,
    MODE_DIV  = 4'd3,
    MODE_LT   = 4'd4,
    MODE_LE   = 4'd5,
    MODE_GT   = 4'd6,
    MODE_GE   = 4'd7,
    MODE_EQ   = 4'd8,
    MODE_NE   = 4'd9,
    MODE_MIN  = 4'd10,
    MODE_MAX  = 4'd11,
    MODE_INC  = 4'd12,
    MODE_DEC  = 4'd13,
    MODE_FINT = 4'd14,
    MODE_TINT = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

endpackage

/* src/qfa_if.sv */
`timescale 1ns / 1ps
interface qfa_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   mode;
  logic signed [DATA_WIDTH-1:0] a_operand;
  logic signed [DATA_WIDTH-1:0] b_operand;
  modport source (output valid, mode, a_operand, b_operand, input ready);
  modport sink (input valid, mode, a_operand, b_operand, output ready);
endinterface

interface qfa_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         compare_true;
  logic                         overflow_flag;
  logic                         divide_by_zero;
  modport source (output valid, result_value, compare_true, overflow_flag, divide_by_zero,
                  input ready);
  modport sink (input valid, result_value, compare_true, overflow_flag, divide_by_zero,
                output ready);
endinterface

/* src/qfa_front.sv */
`timescale 1ns / 1ps
module qfa_front
  import qfa_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    mode,
  input  logic signed [DATA_WIDTH-1:0]  a_operand,
  input  logic signed [DATA_WIDTH-1:0]  b_operand,
  output logic                          q_valid,
  input  logic                          q_ready,
  output cls_t                          q_cls,
  output logic signed [DATA_WIDTH-1:0]  q_simple,
  output logic [2:0]                    q_flags,
  output logic signed [DATA_WIDTH-1:0]  q_a,
  output logic signed [DATA_WIDTH-1:0]  q_b
);
  localparam logic signed [DATA_WIDTH:0] MaxV = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH:0] MinV = {2'b11, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH:0]              sum, dif, sat_s, sat_d;
  logic signed [DATA_WIDTH+FRACTION_BITS:0] fx;
  logic                                    lt, eq, ov_s, ov_d, ov_f;
  logic signed [DATA_WIDTH-1:0]            r, fxs;
  logic                                    cmp, ov;
  cls_t                                    cls;

  logic                                    v;
  cls_t                                    c;
  logic signed [DATA_WIDTH-1:0]            sv, ra, rb;
  logic [2:0]                              fl;

  always_comb begin
    sum = {a_operand[DATA_WIDTH-1], a_operand} + {b_operand[DATA_WIDTH-1], b_operand};
    dif = {a_operand[DATA_WIDTH-1], a_operand} - {b_operand[DATA_WIDTH-1], b_operand};
    ov_s = sum > MaxV || sum < MinV;
    ov_d = dif > MaxV || dif < MinV;
    sat_s = sum > MaxV ? MaxV : (sum < MinV ? MinV : sum);
    sat_d = dif > MaxV ? MaxV : (dif < MinV ? MinV : dif);
    fx = {{(FRACTION_BITS+1){a_operand[DATA_WIDTH-1]}}, a_operand} <<< FRACTION_BITS;
    ov_f = fx[DATA_WIDTH+FRACTION_BITS:DATA_WIDTH-1] != {(FRACTION_BITS+2){fx[DATA_WIDTH-1]}};
    fxs = ov_f ? (a_operand[DATA_WIDTH-1] ? MinV[DATA_WIDTH-1:0] : MaxV[DATA_WIDTH-1:0])
               : fx[DATA_WIDTH-1:0];
    lt = a_operand < b_operand;
    eq = a_operand == b_operand;
    r = '0;
    cmp = 1'b0;
    ov = 1'b0;
    cls = CLS_SIMPLE;
    case (mode_t'(mode))
      MODE_ADD: begin r = sat_s[DATA_WIDTH-1:0]; ov = ov_s; end
      MODE_SUB: begin r = sat_d[DATA_WIDTH-1:0]; ov = ov_d; end
      MODE_MUL: cls = CLS_MUL;
      MODE_DIV: cls = CLS_DIV;
      MODE_LT:  cmp = lt;
      MODE_LE:  cmp = lt | eq;
      MODE_GT:  cmp = !(lt | eq);
      MODE_GE:  cmp = !lt;
      MODE_EQ:  cmp = eq;
      MODE_NE:  cmp = !eq;
      MODE_MIN: r = (lt | eq) ? a_operand : b_operand;
      MODE_MAX: r = (lt | eq) ? b_operand : a_operand;
      MODE_INC: begin
        ov = a_operand == MaxV[DATA_WIDTH-1:0];
        r = ov ? a_operand : a_operand + DATA_WIDTH'(1);
      end
      MODE_DEC: begin
        ov = a_operand == MinV[DATA_WIDTH-1:0];
        r = ov ? a_operand : a_operand - DATA_WIDTH'(1);
      end
      MODE_FINT: begin r = fxs; ov = ov_f; end
      MODE_TINT: r = a_operand >>> FRACTION_BITS;
      default: r = '0;
    endcase
  end

  assign in_ready = !v || q_ready;
  assign q_valid  = v;
  assign q_cls    = c;
  assign q_simple = sv;
  assign q_flags  = fl;
  assign q_a      = ra;
  assign q_b      = rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
    if (in_ready && in_valid) begin
      c  <= cls;
      sv <= r;
      fl <= {1'b0, ov, cmp};
      ra <= a_operand;
      rb <= b_operand;
    end
  end
endmodule

/* src/qfa_back.sv */
`timescale 1ns / 1ps
module qfa_back
  import qfa_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  cls_t                          q_cls,
  input  logic signed [DATA_WIDTH-1:0]  q_simple,
  input  logic [2:0]                    q_flags,
  input  logic signed [DATA_WIDTH-1:0]  q_a,
  input  logic signed [DATA_WIDTH-1:0]  q_b,
  output logic                          o_valid,
  input  logic                          o_ready,
  output logic signed [DATA_WIDTH-1:0]  o_value,
  output logic [2:0]                    o_flags
);
  // Pipeline stages: 0 = capture/magnitudes, 1..NQ = restoring division bits,
  // NQ+1 = rounding/saturation. Multiplier result settles in the same depth.
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NW = W + F + 1;           // dividend (doubled) magnitude width
  localparam int NQ = NW;                  // quotient bits
  localparam int PW = 2 * W;
  localparam int S  = NQ + 2;

  logic [S-1:0]      sv;
  cls_t              sc   [S];
  logic [W-1:0]      ssim [S];
  logic [2:0]        sfl  [S];
  logic              sneg [S];
  logic [NW-1:0]     sden [S];             // 2*|b|
  logic [NW-1:0]     srem [S];
  logic [NW-1:0]     snum [S];             // dividend bits being shifted in
  logic [NQ-1:0]     squo [S];
  logic [PW-1:0]     sprod[S];

  logic              adv;
  logic [W-1:0]      am, bm;
  logic [PW-1:0]     pm;
  logic [NW:0]       trial [S];
  logic [NW:0]       rsh   [S];

  assign adv     = !sv[S-1] || o_ready;
  assign q_ready = adv;
  assign o_valid = sv[S-1];

  always_comb begin
    am = q_a[W-1] ? W'(-q_a) : q_a;
    bm = q_b[W-1] ? W'(-q_b) : q_b;
    pm = PW'(am) * PW'(bm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[S-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc[0]    <= q_cls;
      ssim[0]  <= q_simple;
      sfl[0]   <= q_flags;
      sneg[0]  <= q_a[W-1] ^ q_b[W-1];
      sden[0]  <= {bm, 1'b0};
      srem[0]  <= '0;
      // doubled dividend 2*|a|*2^F + |b|, handled as 2|a|2^F then +|b| at round
      snum[0]  <= {am, {F{1'b0}}, 1'b0};
      squo[0]  <= '0;
      sprod[0] <= pm;
    end
  end

  genvar g;
  generate
    for (g = 1; g <= NQ; g++) begin : g_div
      always_comb begin
        rsh[g]   = {srem[g-1], snum[g-1][NW-1]};
        trial[g] = rsh[g] - {1'b0, sden[g-1]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sc[g]    <= sc[g-1];
          ssim[g]  <= ssim[g-1];
          sfl[g]   <= sfl[g-1];
          sneg[g]  <= sneg[g-1];
          sden[g]  <= sden[g-1];
          snum[g]  <= snum[g-1] << 1;
          sprod[g] <= sprod[g-1];
          if (!trial[g][NW]) begin
            srem[g] <= trial[g][NW-1:0];
            squo[g] <= {squo[g-1][NQ-2:0], 1'b1};
          end else begin
            srem[g] <= rsh[g][NW-1:0];
            squo[g] <= {squo[g-1][NQ-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // (2m + d) / 2d: q = floor(2m/2d) + (rem >= d) i.e. round half up on magnitude
  logic [NQ:0]      dq;
  logic [PW-F:0]    mq;
  logic [PW-F+1:0]  mag;
  logic             ovf, dz;
  logic [W-1:0]     res;
  logic [W-1:0]     lim;

  always_comb begin
    dq  = {1'b0, squo[NQ]} + (NQ+1)'(srem[NQ] >= {1'b0, sden[NQ][NW-1:1]});
    mq  = {1'b0, sprod[NQ][PW-1:F]} + (PW-F+1)'(sprod[NQ][F-1]);
    mag = (sc[NQ] == CLS_MUL) ? {1'b0, mq} : (PW-F+2)'(dq);
    lim = sneg[NQ] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    dz  = (sc[NQ] == CLS_DIV) && (sden[NQ] == '0);
    ovf = !dz && (mag > (PW-F+2)'(lim) + (PW-F+2)'(0));
    if (sneg[NQ] && mag == (PW-F+2)'({1'b0, lim})) ovf = 1'b0;
    if (dz) res = '0;
    else if (ovf) res = lim;
    else if (sneg[NQ]) res = W'(-mag);
    else res = mag[W-1:0];
    if (sneg[NQ] && !ovf && !dz && mag > (PW-F+2)'(lim)) res = lim;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc[S-1]  <= sc[NQ];
      if (sc[NQ] == CLS_SIMPLE) begin
        ssim[S-1] <= ssim[NQ];
        sfl[S-1]  <= sfl[NQ];
      end else begin
        ssim[S-1] <= res;
        sfl[S-1]  <= {dz, ovf, 1'b0};
      end
      sneg[S-1] <= 1'b0; sden[S-1] <= '0; srem[S-1] <= '0;
      snum[S-1] <= '0; squo[S-1] <= '0; sprod[S-1] <= '0;
    end
  end

  assign o_value = ssim[S-1];
  assign o_flags = sfl[S-1];

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_flags[2] |-> o_value == '0 && !o_flags[1]) else $error("dz value");
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_flags[0] |-> o_value == '0) else $error("cmp value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_value)) else $error("hold");
`endif
endmodule

/* src/q24_8_fixed_point_alu_top.sv */
`timescale 1ns / 1ps
// Signed Q24.8 ALU. One beat in per cycle while the output is not stalled; every
// result passes the front register and then the pipelined restoring divider,
// which retires one quotient bit per stage. All modes pass through the same stages.
module q24_8_fixed_point_alu_top
  import qfa_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input logic clk,
  input logic rst,
  qfa_in_if.sink    in_ch,
  qfa_out_if.source out_ch
);
  logic                         q_valid, q_ready;
  cls_t                         q_cls;
  logic signed [DATA_WIDTH-1:0] q_simple, q_a, q_b, o_value;
  logic [2:0]                   q_flags, o_flags;

  qfa_front #(.DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .mode(in_ch.mode),
    .a_operand(in_ch.a_operand), .b_operand(in_ch.b_operand),
    .q_valid, .q_ready, .q_cls, .q_simple, .q_flags, .q_a, .q_b
  );

  qfa_back #(.DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cls, .q_simple, .q_flags, .q_a, .q_b,
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_value, .o_flags
  );

  assign out_ch.result_value   = o_value;
  assign out_ch.compare_true   = o_flags[0];
  assign out_ch.overflow_flag  = o_flags[1];
  assign out_ch.divide_by_zero = o_flags[2];
endmodule

/* tb/tb_if.sv */
`timescale 1ns / 1ps
// The block's own interfaces (qfa_in_if, qfa_out_if) live in src/qfa_if.sv.
// This file holds the small record types (operation and expected result) that the testbench keeps for each beat.
package tb_beat_pkg;
  import qfa_pkg::*;

  typedef struct {
    mode_t             mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_op_t;

  typedef struct {
    logic signed [31:0] value;
    logic               cmp;
    logic               ovf;
    logic               dz;
  } alu_res_t;
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import qfa_pkg::*;
  import tb_beat_pkg::*;

  localparam int FRAC = 8;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam int LIMIT = 20000;

  logic clk;
  logic rst;
  qfa_in_if  #(.DATA_WIDTH(32)) in_ch ();
  qfa_out_if #(.DATA_WIDTH(32)) out_ch ();

  q24_8_fixed_point_alu_top u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  alu_op_t  op_q[$];
  alu_res_t want_q[$];
  int       errors;
  int       mismatches;
  int       idle_cycles;
  bit       stim_done;
  bit       calm;
  bit       sink_hold;
  bit       hold_go;
  bit       src_pause;
  bit       in_taken;

  function automatic longint saturate(longint v, inout logic ovf);
    if (v > MAXV) begin
      ovf = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      ovf = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t r;
    longint a, b, v, num, den;
    a = op.a;
    b = op.b;
    v = 0;
    r.cmp = 0;
    r.ovf = 0;
    r.dz = 0;
    case (op.mode)
      MODE_ADD: v = saturate(a + b, r.ovf);
      MODE_SUB: v = saturate(a - b, r.ovf);
      MODE_MUL: v = saturate(round_div(a * b, 64'sd1 <<< FRAC), r.ovf);
      MODE_DIV: begin
        if (b == 0) begin
          r.dz = 1;
        end else begin
          num = a <<< FRAC;
          den = b;
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          v = saturate(round_div(num, den), r.ovf);
        end
      end
      MODE_LT: r.cmp = a < b;
      MODE_LE: r.cmp = a <= b;
      MODE_GT: r.cmp = a > b;
      MODE_GE: r.cmp = a >= b;
      MODE_EQ: r.cmp = a == b;
      MODE_NE: r.cmp = a != b;
      MODE_MIN: v = (a <= b) ? a : b;
      MODE_MAX: v = (a > b) ? a : b;
      MODE_INC: begin
        if (a < MAXV) v = a + 1;
        else begin
          v = a;
          r.ovf = 1;
        end
      end
      MODE_DEC: begin
        if (a > MINV) v = a - 1;
        else begin
          v = a;
          r.ovf = 1;
        end
      end
      MODE_FINT: v = saturate(a <<< FRAC, r.ovf);
      default: v = a >>> FRAC;
    endcase
    r.value = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 3) - 1;
      3, 4: return $signed($urandom_range(0, 4096)) - 2048;
      5, 6: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(mode_t m, logic [31:0] a, logic [31:0] b);
    alu_op_t op;
    op.mode = m;
    op.a = a;
    op.b = b;
    op_q.push_back(op);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  initial begin
    mode_t m;
    logic [31:0] a;
    logic [31:0] b;
    stim_done = 0;
    calm = 0;
    hold_go = 0;
    src_pause = 0;
    for (int i = 0; i < 16; i++) begin
      m = mode_t'(i);
      push_op(m, 32'h7fffffff, 32'h80000000);
    end
    push_op(MODE_DIV, 32'h00000100, 32'h0);
    push_op(MODE_DIV, 32'h80000000, 32'hffffffff);
    push_op(MODE_MUL, 32'h00000180, 32'h00000001);
    push_op(MODE_MUL, 32'hfffffe80, 32'h00000001);
    push_op(MODE_MUL, 32'h80000000, 32'h80000000);
    push_op(MODE_DIV, 32'h00000001, 32'h00000200);
    push_op(MODE_TINT, 32'hffffff01, 32'h0);
    push_op(MODE_MIN, 32'h00000005, 32'h00000005);
    push_op(MODE_FINT, 32'hff800000, 32'h0);
    wait (!rst);
    for (int i = 0; i < 1600; i++) begin
      m = mode_t'($urandom_range(0, 15));
      a = rand_operand();
      b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
      if (m == MODE_DIV && $urandom_range(0, 15) == 0) b = 0;
      push_op(m, a, b);
      if (i == 300) begin
        wait (op_q.size() == 0 && !in_ch.valid && want_q.size() == 0);
        src_pause = 1;
        repeat (60) @(posedge clk);
        src_pause = 0;
      end
      if (i == 600) hold_go = 1;
      if (i == 900) calm = 1;
      if (i == 1200) calm = 0;
      while (op_q.size() > 40) @(posedge clk);
    end
    wait (op_q.size() == 0 && !in_ch.valid);
    stim_done = 1;
  end

  initial begin
    sink_hold = 0;
    wait (hold_go);
    sink_hold = 1;
    repeat (200) @(posedge clk);
    sink_hold = 0;
  end

  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.mode <= 0;
      in_ch.a_operand <= 0;
      in_ch.b_operand <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (op_q.size() > 0 && !src_pause && (calm || $urandom_range(0, 99) >= 22)) begin
        in_ch.valid <= 1;
        in_ch.mode <= op_q[0].mode;
        in_ch.a_operand <= op_q[0].a;
        in_ch.b_operand <= op_q[0].b;
        op_q.pop_front();
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= !sink_hold && (calm || $urandom_range(0, 99) >= 22);
  end

  initial begin
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.a_operand = 0;
    in_ch.b_operand = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    alu_op_t  op;
    alu_res_t w;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        op.mode = mode_t'(in_ch.mode);
        op.a = in_ch.a_operand;
        op.b = in_ch.b_operand;
        want_q.push_back(alu_predict(op));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (want_q.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result beat value=%h", out_ch.result_value);
          mismatches++;
        end else begin
          w = want_q.pop_front();
          if (out_ch.result_value !== w.value || out_ch.compare_true !== w.cmp ||
              out_ch.overflow_flag !== w.ovf || out_ch.divide_by_zero !== w.dz) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: exp %h c%b o%b z%b got %h c%b o%b z%b",
                       w.value, w.cmp, w.ovf, w.dz, out_ch.result_value,
                       out_ch.compare_true, out_ch.overflow_flag, out_ch.divide_by_zero);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("q24_8_fixed_point_alu_top verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    mismatches = 0;
    wait (stim_done);
    wait (want_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) begin
      $display("q24_8_fixed_point_alu_top verification clean");
    end else begin
      $display("q24_8_fixed_point_alu_top verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/qfa_pkg.sv
src/qfa_if.sv
src/qfa_front.sv
src/qfa_back.sv
src/q24_8_fixed_point_alu_top.sv
tb/tb_if.sv
tb/tb_top.sv
